### src/fix_message_validator_defines.svh
// Assertion macros used by the validator top level.
`ifndef FIX_MESSAGE_VALIDATOR_DEFINES_SVH
`define FIX_MESSAGE_VALIDATOR_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define FMV_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define FMV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### src/fmv_pkg.sv
// Shared types and constants of the FIX message validator.
package fmv_pkg;
    localparam int BEGIN_BYTES = 7;
    localparam int LENGTH_BITS = 16;
    localparam int MSG_BITS = LENGTH_BITS + 1;
    localparam int KEY_BITS = 20;
    localparam int BEGIN_BITS = 8 * BEGIN_BYTES;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
    localparam logic [MSG_BITS-1:0] MSG_MAX = '1;
    localparam logic [KEY_BITS-1:0] KEY_MAX = '1;
    localparam logic [7:0] SOH_BYTE = 8'h01;
    localparam logic [7:0] EQ_BYTE = 8'h3D;
    localparam logic [BEGIN_BITS-1:0] BEGIN_RESET = 56'd19780516010012209;
    localparam logic [15:0] MAX_BODY_RESET = 16'd4096;
    localparam logic [0:0] REG_BEGIN = 1'b0;
    localparam logic [0:0] REG_MAXBODY = 1'b1;

    typedef enum logic [3:0] {
        ST_IN_TAG = 4'd0, ST_HEADER_OK = 4'd1, ST_BODY_TAG = 4'd2, ST_MSG_OK = 4'd3,
        ST_NO_EQUALS = 4'd4, ST_BAD_KEY = 4'd5, ST_BAD_BEGIN = 4'd6,
        ST_BAD_LENGTH = 4'd7, ST_BAD_CHECKSUM = 4'd8, ST_INCOMPLETE = 4'd9
    } status_t;

    typedef struct packed {
        status_t status;
        logic [KEY_BITS-1:0] tag_key;
        logic [LENGTH_BITS-1:0] value_length;
        logic [MSG_BITS-1:0] message_length;
    } result_t;
endpackage

### src/fmv_parser.sv
// Front part: byte classification, tag accumulation and message checks.
module fmv_parser
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [0:0] cfg_idx,
    input  logic [fmv_pkg::BEGIN_BITS-1:0] cfg_data,
    input  logic in_fire,
    input  logic [7:0] data_byte,
    input  logic last_available,
    output fmv_pkg::result_t result
);
    localparam int LB = fmv_pkg::LENGTH_BITS;
    localparam int MB = fmv_pkg::MSG_BITS;
    localparam int KB = fmv_pkg::KEY_BITS;
    localparam int VCB = $clog2(fmv_pkg::BEGIN_BYTES + 1);

    typedef enum logic [1:0] {POS_BEGIN, POS_LENGTH, POS_BODY} pos_t;
    typedef enum logic [1:0] {KEY_NONE, KEY_DIGITS, KEY_ENDED, KEY_BAD} kph_t;

    logic [fmv_pkg::BEGIN_BITS-1:0] begin_reg;
    logic [15:0] maxb_reg;
    pos_t pos_reg, pos_next;
    logic [LB-1:0] target_reg, target_next;
    logic [MB-1:0] parsed_reg, parsed_next;
    logic [7:0] rsum_reg, rsum_next, sbt_reg, sbt_next;
    logic [MB-1:0] bytes_reg, bytes_next;
    logic [LB-1:0] tlen_reg, tlen_next;
    logic [KB-1:0] key_reg, key_next;
    kph_t kph_reg, kph_next;
    logic eq_reg, eq_next;
    logic [LB-1:0] vcnt_reg, vcnt_next;
    logic [MB-1:0] vnum_reg, vnum_next;
    logic fbeg_reg, fbeg_next, fdig_reg, fdig_next;

    logic is_dig;
    logic [KB+3:0] kmul;
    logic [MB+3:0] nmul;
    logic [7:0] exp_byte;
    logic [MB:0] sum_a, sum_b;
    logic [MB-1:0] parsed_sat;

    always_comb
    begin
        logic clr_msg, clr_tag, digits;
        fmv_pkg::status_t st;
        logic [KB-1:0] ko;
        logic [LB-1:0] vo;
        logic [MB-1:0] mo;
        clr_msg = 1'b0;
        clr_tag = 1'b0;
        st = fmv_pkg::ST_IN_TAG;
        ko = '0;
        vo = '0;
        mo = '0;
        is_dig = data_byte >= 8'h30 && data_byte <= 8'h39;
        pos_next = pos_reg;
        target_next = target_reg;
        parsed_next = parsed_reg;
        sbt_next = sbt_reg;
        bytes_next = bytes_reg;
        key_next = key_reg;
        kph_next = kph_reg;
        eq_next = eq_reg;
        vcnt_next = vcnt_reg;
        vnum_next = vnum_reg;
        fbeg_next = fbeg_reg;
        fdig_next = fdig_reg;
        rsum_next = rsum_reg + data_byte;
        tlen_next = (tlen_reg != fmv_pkg::LEN_MAX) ? tlen_reg + 1'b1 : tlen_reg;
        kmul = {4'd0, key_reg} * 24'd10 + {20'd0, data_byte[3:0]};
        nmul = {4'd0, vnum_reg} * 21'd10 + {17'd0, data_byte[3:0]};
        exp_byte = begin_reg[8*(fmv_pkg::BEGIN_BYTES-1) - 8*vcnt_reg[VCB-1:0] +: 8];
        sum_a = {1'b0, parsed_reg} + {2'b0, tlen_next};
        parsed_sat = sum_a[MB] ? fmv_pkg::MSG_MAX : sum_a[MB-1:0];
        sum_b = {1'b0, bytes_reg} + {2'b0, tlen_next};
        digits = fdig_reg && vcnt_reg != '0;
        if (data_byte != fmv_pkg::SOH_BYTE)
        begin
            if (kph_reg == KEY_NONE)
            begin
                if (is_dig)
                    kph_next = KEY_DIGITS;
                else
                    kph_next = KEY_BAD;
            end
            else if (kph_reg == KEY_DIGITS && !is_dig)
                kph_next = KEY_ENDED;
            if (kph_next == KEY_DIGITS)
                key_next = (kmul > {4'd0, fmv_pkg::KEY_MAX}) ? fmv_pkg::KEY_MAX
                                                             : kmul[KB-1:0];
            if (data_byte == fmv_pkg::EQ_BYTE)
            begin
                eq_next = 1'b1;
                vcnt_next = '0;
                vnum_next = '0;
                fbeg_next = 1'b1;
                fdig_next = 1'b1;
            end
            else if (eq_reg)
            begin
                if (vcnt_reg >= LB'(fmv_pkg::BEGIN_BYTES) || exp_byte != data_byte)
                    fbeg_next = 1'b0;
                if (is_dig)
                    vnum_next = (nmul > {4'd0, fmv_pkg::MSG_MAX}) ? fmv_pkg::MSG_MAX
                                                                  : nmul[MB-1:0];
                else
                    fdig_next = 1'b0;
                if (vcnt_reg != fmv_pkg::LEN_MAX)
                    vcnt_next = vcnt_reg + 1'b1;
            end
            if (last_available)
            begin
                st = fmv_pkg::ST_INCOMPLETE;
                clr_msg = 1'b1;
            end
        end
        else
        begin
            if (!eq_reg)
                st = fmv_pkg::ST_NO_EQUALS;
            else if (kph_reg == KEY_NONE || kph_reg == KEY_BAD)
                st = fmv_pkg::ST_BAD_KEY;
            else
            begin
                ko = key_reg;
                vo = vcnt_reg;
                if (pos_reg == POS_BEGIN)
                begin
                    if (key_reg == KB'(8) && fbeg_reg &&
                        vcnt_reg == LB'(fmv_pkg::BEGIN_BYTES))
                    begin
                        st = fmv_pkg::ST_HEADER_OK;
                        pos_next = POS_LENGTH;
                    end
                    else
                        st = fmv_pkg::ST_BAD_BEGIN;
                end
                else if (pos_reg == POS_LENGTH)
                begin
                    if (key_reg == KB'(9) && digits && vnum_reg <= {1'b0, maxb_reg})
                    begin
                        st = fmv_pkg::ST_HEADER_OK;
                        target_next = vnum_reg[LB-1:0];
                        pos_next = POS_BODY;
                    end
                    else
                        st = fmv_pkg::ST_BAD_LENGTH;
                end
                else if (parsed_reg == {1'b0, target_reg})
                begin
                    if (key_reg == KB'(10) && digits && vcnt_reg == LB'(3) &&
                        vnum_reg == {9'd0, sbt_reg})
                    begin
                        st = fmv_pkg::ST_MSG_OK;
                        mo = sum_b[MB] ? fmv_pkg::MSG_MAX : sum_b[MB-1:0];
                    end
                    else
                        st = fmv_pkg::ST_BAD_CHECKSUM;
                end
                else
                begin
                    parsed_next = parsed_sat;
                    if (parsed_sat > {1'b0, target_reg})
                        st = fmv_pkg::ST_BAD_LENGTH;
                    else
                        st = fmv_pkg::ST_BODY_TAG;
                end
            end
            if (st >= fmv_pkg::ST_MSG_OK)
                clr_msg = 1'b1;
            else
            begin
                bytes_next = sum_b[MB] ? fmv_pkg::MSG_MAX : sum_b[MB-1:0];
                sbt_next = rsum_next;
                clr_tag = 1'b1;
                if (last_available)
                begin
                    st = fmv_pkg::ST_INCOMPLETE;
                    clr_msg = 1'b1;
                end
            end
        end
        if (clr_msg)
        begin
            pos_next = POS_BEGIN;
            target_next = '0;
            parsed_next = '0;
            rsum_next = '0;
            sbt_next = '0;
            bytes_next = '0;
            clr_tag = 1'b1;
        end
        if (clr_tag)
        begin
            tlen_next = '0;
            key_next = '0;
            kph_next = KEY_NONE;
            eq_next = 1'b0;
            vcnt_next = '0;
            vnum_next = '0;
            fbeg_next = 1'b1;
            fdig_next = 1'b1;
        end
        result.status = st;
        result.tag_key = ko;
        result.value_length = vo;
        result.message_length = mo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            begin_reg <= fmv_pkg::BEGIN_RESET;
            maxb_reg <= fmv_pkg::MAX_BODY_RESET;
            pos_reg <= POS_BEGIN;
            target_reg <= '0;
            parsed_reg <= '0;
            rsum_reg <= '0;
            sbt_reg <= '0;
            bytes_reg <= '0;
            tlen_reg <= '0;
            key_reg <= '0;
            kph_reg <= KEY_NONE;
            eq_reg <= 1'b0;
            vcnt_reg <= '0;
            vnum_reg <= '0;
            fbeg_reg <= 1'b1;
            fdig_reg <= 1'b1;
        end
        else
        begin
            if (cfg_we && cfg_idx == fmv_pkg::REG_BEGIN)
                begin_reg <= cfg_data;
            if (cfg_we && cfg_idx == fmv_pkg::REG_MAXBODY)
                maxb_reg <= cfg_data[15:0];
            if (in_fire)
            begin
                pos_reg <= pos_next;
                target_reg <= target_next;
                parsed_reg <= parsed_next;
                rsum_reg <= rsum_next;
                sbt_reg <= sbt_next;
                bytes_reg <= bytes_next;
                tlen_reg <= tlen_next;
                key_reg <= key_next;
                kph_reg <= kph_next;
                eq_reg <= eq_next;
                vcnt_reg <= vcnt_next;
                vnum_reg <= vnum_next;
                fbeg_reg <= fbeg_next;
                fdig_reg <= fdig_next;
            end
        end
    end
endmodule

### src/fmv_queue.sv
// Back part: two-entry result queue that drives the output channel.
module fmv_queue
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  fmv_pkg::result_t din,
    output logic full,
    output logic out_valid,
    input  logic out_stall,
    output fmv_pkg::result_t dout
);
    fmv_pkg::result_t mem_reg [2];
    logic rd_reg, wr_reg;
    logic [1:0] cnt_reg;
    logic pop;

    assign pop = out_valid && !out_stall;
    assign out_valid = cnt_reg != 2'd0;
    assign full = cnt_reg == 2'd2;
    assign dout = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= !wr_reg;
            if (pop)
                rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

### src/fix_message_validator.sv
// Top level of the FIX message validator.
// One result beat per accepted byte, one byte per cycle sustained: the parser updates
// all its counters and checks combinationally for each accepted byte, and a two-entry
// result queue absorbs output stalls so that the input can keep flowing; input stalls
// only when both entries hold undelivered results.
`include "fix_message_validator_defines.svh"
module fix_message_validator
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [0:0] cfg_idx,
    input  logic [fmv_pkg::BEGIN_BITS-1:0] cfg_data,
    input  logic in_valid,
    output logic in_stall,
    input  logic [7:0] data_byte,
    input  logic last_available,
    output logic out_valid,
    input  logic out_stall,
    output logic [3:0] status,
    output logic [fmv_pkg::KEY_BITS-1:0] tag_key,
    output logic [fmv_pkg::LENGTH_BITS-1:0] value_length,
    output logic [fmv_pkg::MSG_BITS-1:0] message_length
);
    fmv_pkg::result_t res, qout;
    logic full, in_fire;

    assign in_stall = full;
    assign in_fire = in_valid && !full;

    fmv_parser u_parser (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
        .cfg_data(cfg_data), .in_fire(in_fire), .data_byte(data_byte),
        .last_available(last_available), .result(res)
    );

    fmv_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(in_fire), .din(res), .full(full),
        .out_valid(out_valid), .out_stall(out_stall), .dout(qout)
    );

    assign status = qout.status;
    assign tag_key = qout.tag_key;
    assign value_length = qout.value_length;
    assign message_length = qout.message_length;

    `FMV_ASSERT_IMP(a_fire_not_full, in_fire, !full)
    `FMV_ASSERT_NEXT(a_fire_gives_valid, in_fire, out_valid)
    `FMV_ASSERT_IMP(a_mlen_only_ok, out_valid && status != fmv_pkg::ST_MSG_OK, message_length == '0)
endmodule

### tb/tb_fix_message_validator.sv
// Self-checking testbench of the FIX message validator: directed and random byte streams.
module tb_fix_message_validator;
    localparam int BB = fmv_pkg::BEGIN_BITS;
    localparam int NBYTES = fmv_pkg::BEGIN_BYTES;
    localparam int KB = fmv_pkg::KEY_BITS;
    localparam int LB = fmv_pkg::LENGTH_BITS;
    localparam int MB = fmv_pkg::MSG_BITS;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       has_expected;
        logic [3:0] status;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [0:0] cfg_idx;
    logic [BB-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [7:0] data_byte;
    logic last_available;
    logic out_valid;
    logic out_stall;
    logic [3:0] status;
    logic [KB-1:0] tag_key;
    logic [LB-1:0] value_length;
    logic [MB-1:0] message_length;

    fix_message_validator uut (.*);

    // Predictor state.
    logic [BB-1:0] p_begin;
    logic [15:0] p_max_body;
    int unsigned p_pos, p_target, p_parsed, p_sum, p_sum_before, p_bytes;
    int unsigned p_tag_len, p_key, p_key_phase, p_eq, p_vcount, p_vnum;
    bit p_begin_ok, p_digits_ok;

    fmv_pkg::result_t expected_results[$];
    int fail_count;
    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    bit hold_off;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic bit is_digit(input int unsigned b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic void clear_value();
        p_vcount = 0;
        p_vnum = 0;
        p_begin_ok = 1'b1;
        p_digits_ok = 1'b1;
    endfunction

    function automatic void clear_tag();
        p_tag_len = 0;
        p_key = 0;
        p_key_phase = 0;
        p_eq = 0;
        clear_value();
    endfunction

    function automatic void clear_message();
        p_pos = 0;
        p_target = 0;
        p_parsed = 0;
        p_sum = 0;
        p_sum_before = 0;
        p_bytes = 0;
        clear_tag();
    endfunction

    function automatic fmv_pkg::result_t validate_byte(input logic [7:0] b, input logic last);
        fmv_pkg::result_t r;
        int unsigned n, tlen;
        bit digits;
        r = '0;
        r.status = fmv_pkg::ST_IN_TAG;
        p_sum = (p_sum + b) & 8'hFF;
        if (p_tag_len < fmv_pkg::LEN_MAX)
            p_tag_len++;
        if (b != fmv_pkg::SOH_BYTE)
        begin
            if (p_key_phase == 0)
                p_key_phase = is_digit(b) ? 1 : 3;
            else if (p_key_phase == 1 && !is_digit(b))
                p_key_phase = 2;
            if (p_key_phase == 1)
            begin
                n = p_key * 10 + (b - 8'h30);
                p_key = (p_key > fmv_pkg::KEY_MAX / 10 || n > fmv_pkg::KEY_MAX)
                        ? fmv_pkg::KEY_MAX : n;
            end
            if (b == fmv_pkg::EQ_BYTE)
            begin
                p_eq = 1;
                clear_value();
            end
            else if (p_eq)
            begin
                if (p_vcount < NBYTES)
                begin
                    if (p_begin[8 * (NBYTES - 1 - p_vcount) +: 8] != b)
                        p_begin_ok = 1'b0;
                end
                else
                    p_begin_ok = 1'b0;
                if (is_digit(b))
                begin
                    n = p_vnum * 10 + (b - 8'h30);
                    p_vnum = (p_vnum > fmv_pkg::MSG_MAX / 10 || n > fmv_pkg::MSG_MAX)
                             ? fmv_pkg::MSG_MAX : n;
                end
                else
                    p_digits_ok = 1'b0;
                if (p_vcount < fmv_pkg::LEN_MAX)
                    p_vcount++;
            end
            if (last)
            begin
                r.status = fmv_pkg::ST_INCOMPLETE;
                clear_message();
            end
        end
        else
        begin
            digits = p_digits_ok && p_vcount != 0;
            tlen = p_tag_len;
            if (!p_eq)
                r.status = fmv_pkg::ST_NO_EQUALS;
            else if (p_key_phase == 0 || p_key_phase == 3)
                r.status = fmv_pkg::ST_BAD_KEY;
            else
            begin
                r.tag_key = KB'(p_key);
                r.value_length = LB'(p_vcount);
                if (p_pos == 0)
                begin
                    if (p_key == 8 && p_begin_ok && p_vcount == NBYTES)
                    begin
                        r.status = fmv_pkg::ST_HEADER_OK;
                        p_pos = 1;
                    end
                    else
                        r.status = fmv_pkg::ST_BAD_BEGIN;
                end
                else if (p_pos == 1)
                begin
                    if (p_key == 9 && digits && p_vnum <= p_max_body)
                    begin
                        r.status = fmv_pkg::ST_HEADER_OK;
                        p_target = p_vnum;
                        p_pos = 2;
                    end
                    else
                        r.status = fmv_pkg::ST_BAD_LENGTH;
                end
                else if (p_parsed == p_target)
                begin
                    if (p_key == 10 && digits && p_vcount == 3 && p_vnum == p_sum_before)
                    begin
                        r.status = fmv_pkg::ST_MSG_OK;
                        n = p_bytes + tlen;
                        r.message_length = MB'((n > fmv_pkg::MSG_MAX) ? fmv_pkg::MSG_MAX : n);
                    end
                    else
                        r.status = fmv_pkg::ST_BAD_CHECKSUM;
                end
                else
                begin
                    p_parsed += tlen;
                    if (p_parsed > fmv_pkg::MSG_MAX)
                        p_parsed = fmv_pkg::MSG_MAX;
                    if (p_parsed > p_target)
                        r.status = fmv_pkg::ST_BAD_LENGTH;
                    else
                        r.status = fmv_pkg::ST_BODY_TAG;
                end
            end
            if (r.status >= fmv_pkg::ST_MSG_OK)
                clear_message();
            else
            begin
                p_bytes += tlen;
                if (p_bytes > fmv_pkg::MSG_MAX)
                    p_bytes = fmv_pkg::MSG_MAX;
                p_sum_before = p_sum;
                clear_tag();
                if (last)
                begin
                    r.status = fmv_pkg::ST_INCOMPLETE;
                    clear_message();
                end
            end
        end
        return r;
    endfunction

    task automatic write_register(input logic [0:0] idx, input logic [BB-1:0] value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == fmv_pkg::REG_BEGIN)
            p_begin = value;
        else
            p_max_body = value[15:0];
        @(posedge clk);
    endtask

    // Offers one byte, holding it until accepted, and files the expected result.
    task automatic send_byte(input logic [7:0] b, input logic last, input bit check_status,
                             input logic [3:0] want);
        fmv_pkg::result_t r;
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        last_available <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        r = validate_byte(b, last);
        if (check_status && r.status != want)
        begin
            $error("directed status: expected %0d, actual %0d", want, r.status);
            fail_count++;
        end
        expected_results.push_back(r);
    endtask

    task automatic send_text(input string s, input bit last_on_end);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], last_on_end && i == s.len() - 1, 1'b0, 4'd0);
    endtask

    // Builds a well-formed message around a random body; corrupts it when corrupt is set.
    task automatic send_message(input bit corrupt);
        string body, msg, tag;
        int unsigned sum, ntags;
        body = "";
        ntags = $urandom_range(3, 0);
        for (int t = 0; t < ntags; t++)
        begin
            tag = $sformatf("%0d=", $urandom_range(999, 11));
            for (int k = $urandom_range(4, 0); k > 0; k--)
                tag = {tag, string'(8'($urandom_range(126, 32)))};
            body = {body, tag, "\001"};
        end
        msg = "8=";
        for (int i = 0; i < NBYTES; i++)
            msg = {msg, string'(p_begin[8 * (NBYTES - 1 - i) +: 8])};
        msg = {msg, "\001", $sformatf("9=%0d\001", body.len()), body};
        sum = 0;
        for (int i = 0; i < msg.len(); i++)
            sum += msg[i];
        msg = {msg, $sformatf("10=%03d\001", sum % 256)};
        if (corrupt)
            msg[$urandom_range(msg.len() - 1, 0)] = 8'($urandom);
        for (int i = 0; i < msg.len(); i++)
            send_byte(msg[i], corrupt && $urandom_range(9, 0) == 0, 1'b0, 4'd0);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (40) @(posedge clk);
                out_stall <= 1'b0;
                hold_off = 1'b0;
            end
            else
                out_stall <= recv_idle_pct != 0 && $urandom_range(99, 0) < recv_idle_pct;
        end
    end

    initial
    begin
        fmv_pkg::result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        fail_count++;
                    end
                    if (tag_key !== want.tag_key)
                    begin
                        $error("tag_key: expected %0d, actual %0d", want.tag_key, tag_key);
                        fail_count++;
                    end
                    if (value_length !== want.value_length)
                    begin
                        $error("value_length: expected %0d, actual %0d",
                               want.value_length, value_length);
                        fail_count++;
                    end
                    if (message_length !== want.message_length)
                    begin
                        $error("message_length: expected %0d, actual %0d",
                               want.message_length, message_length);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        stim_row_t directed [];
        int sent;
        directed = '{
            '{8'h01, 1'b0, 1'b1, fmv_pkg::ST_NO_EQUALS},
            '{8'h3D, 1'b0, 1'b0, 4'd0},
            '{8'h01, 1'b0, 1'b1, fmv_pkg::ST_BAD_KEY},
            '{8'h2D, 1'b0, 1'b1, fmv_pkg::ST_IN_TAG},
            '{8'h3D, 1'b0, 1'b0, 4'd0},
            '{8'h01, 1'b0, 1'b1, fmv_pkg::ST_BAD_KEY},
            '{8'h38, 1'b0, 1'b0, 4'd0},
            '{8'h3D, 1'b0, 1'b0, 4'd0},
            '{8'hFF, 1'b0, 1'b0, 4'd0},
            '{8'h01, 1'b0, 1'b1, fmv_pkg::ST_BAD_BEGIN},
            '{8'h00, 1'b1, 1'b1, fmv_pkg::ST_INCOMPLETE},
            '{8'h37, 1'b0, 1'b0, 4'd0},
            '{8'h3D, 1'b0, 1'b0, 4'd0},
            '{8'h01, 1'b1, 1'b1, fmv_pkg::ST_BAD_BEGIN}
        };
        fail_count = 0;
        items_sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = fmv_pkg::REG_BEGIN;
        cfg_data = '0;
        in_valid = 1'b0;
        data_byte = '0;
        last_available = 1'b0;
        p_begin = fmv_pkg::BEGIN_RESET;
        p_max_body = fmv_pkg::MAX_BODY_RESET;
        clear_message();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_byte(directed[i].data, directed[i].last, directed[i].has_expected,
                      directed[i].status);
        // Good message, an oversized key with two equals signs, a body length over the limit, then a truncated one.
        send_message(1'b0);
        send_text("99999999=a=b\001", 1'b0);
        send_text("8=FIX.4.1\0019=4097\001", 1'b0);
        send_text("8=FIX.4.1\0019=0\00110=", 1'b1);
        wait_drained();

        write_register(fmv_pkg::REG_MAXBODY, BB'(16'd0));
        write_register(fmv_pkg::REG_BEGIN, {BB{1'b1}});
        send_message(1'b0);
        send_text("8=FIX.4.1\001", 1'b0);
        wait_drained();
        write_register(fmv_pkg::REG_BEGIN, '0);
        write_register(fmv_pkg::REG_MAXBODY, BB'(16'hFFFF));
        send_message(1'b0);
        wait_drained();
        write_register(fmv_pkg::REG_BEGIN, fmv_pkg::BEGIN_RESET);
        write_register(fmv_pkg::REG_MAXBODY, BB'(16'd20));

        sent = items_sent;
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 64 : 0;
            recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 34 : 0;
            if (phase == 2)
                hold_off = 1'b1;
            while (items_sent < sent + 150 * (phase + 1))
            begin
                if ($urandom_range(9, 0) < 7)
                    send_message($urandom_range(3, 0) == 0);
                else
                    for (int k = $urandom_range(12, 1); k > 0; k--)
                        send_byte(8'($urandom), $urandom_range(15, 0) == 0, 1'b0, 4'd0);
            end
            wait_drained();
            if (phase == 0)
                write_register(fmv_pkg::REG_BEGIN, BB'($urandom) << 24 | BB'($urandom));
            else if (phase == 1)
            begin
                write_register(fmv_pkg::REG_BEGIN, fmv_pkg::BEGIN_RESET);
                write_register(fmv_pkg::REG_MAXBODY, BB'(fmv_pkg::MAX_BODY_RESET));
            end
        end
        wait_drained();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
